/* src/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define VSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication checked at every clock edge outside reset
`define VSD_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

/* src/vsd_pkg.sv */
// types, constants and the digit step function of the varint stream decoder
package vsd_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_TRUNC    = 2'd2;

    localparam logic       MODE_BYTE   = 1'b0;
    localparam logic       MODE_NIBBLE = 1'b1;

    localparam logic       CFG_DIGIT_MODE  = 1'b0;
    localparam logic       CFG_SIGNED_MODE = 1'b1;

    localparam logic [6:0] BYTE_BITS   = 7'd7;
    localparam logic [6:0] NIB_BITS    = 7'd3;
    localparam logic [3:0] BYTE_LIMIT  = 4'd5;
    localparam logic [3:0] NIB_LIMIT   = 4'd11;
    localparam logic [3:0] CNT_MAX     = 4'd15;
    localparam logic [6:0] ACC_WIDTH   = 7'd32;

    localparam int unsigned Q_DEPTH    = 4;
    localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int unsigned Q_LVL_W    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [31:0] value;
        logic [3:0]  digit_count;
        logic [1:0]  status;
        logic        last_of_item;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    typedef struct packed {
        logic               space_ok;
        logic [Q_LVL_W-1:0] level;
    } t_q_status;

    typedef struct packed {
        logic [31:0] acc;
        logic [3:0]  cnt;
        logic        emit;
        t_result     res;
    } t_step;

    function automatic t_step digit_step(
        logic [31:0] acc,
        logic [3:0]  cnt,
        logic [6:0]  payload,
        logic        more,
        logic        nibble,
        logic        sgn
    );
        t_step       s;
        logic [6:0]  shift;
        logic [31:0] acc_n;
        logic [3:0]  cnt_n;
        logic [3:0]  limit;
        logic [31:0] zz;
        shift = {3'b000, cnt} * (nibble ? NIB_BITS : BYTE_BITS);
        acc_n = acc;
        if (shift < ACC_WIDTH) begin
            acc_n = acc | (32'(payload) << shift[4:0]);
        end
        cnt_n = (cnt != CNT_MAX) ? cnt + 4'd1 : cnt;
        limit = nibble ? NIB_LIMIT : BYTE_LIMIT;
        zz    = (acc_n >> 1) ^ {32{acc_n[0]}};
        s.emit = !more || (cnt_n >= limit);
        s.res.digit_count  = cnt_n;
        s.res.last_of_item = 1'b0;
        s.res.status       = more ? ST_OVERFLOW : ST_OK;
        s.res.value        = (!more && sgn) ? zz : acc_n;
        s.acc = s.emit ? 32'd0 : acc_n;
        s.cnt = s.emit ? 4'd0 : cnt_n;
        return s;
    endfunction

endpackage

/* src/vsd_decode.sv */
// input register, config registers, value state and per-byte digit decoding
module vsd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic              i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_high_half_valid,
    input  logic              i_buffer_end,
    input  vsd_pkg::t_q_status i_q_status,
    output vsd_pkg::t_push    o_push
);
    import vsd_pkg::*;

    logic        r_digit_mode;
    logic        r_signed_mode;
    logic        r_in_valid;
    logic [7:0]  r_data;
    logic        r_high;
    logic        r_end;
    logic [31:0] r_acc;
    logic [3:0]  r_cnt;
    logic [31:0] n_acc;
    logic [3:0]  n_cnt;

    logic        advance;
    logic        accept;
    logic        nibble;
    logic        use_hi;
    logic        e0;
    logic        e1;
    logic        trunc;
    logic [31:0] acc_a;
    logic [3:0]  cnt_a;
    logic [1:0]  n_res;
    t_step       st0;
    t_step       st1;
    t_result     tr_res;
    t_result     slot0;
    t_result     slot1;

    assign advance = r_in_valid && i_q_status.space_ok;
    assign o_stall = r_in_valid && !i_q_status.space_ok;
    assign accept  = i_valid && !o_stall;
    assign nibble  = (r_digit_mode == MODE_NIBBLE);

    always_comb begin
        st0 = digit_step(r_acc, r_cnt,
                         nibble ? {4'b0000, r_data[2:0]} : r_data[6:0],
                         nibble ? r_data[3] : r_data[7],
                         nibble, r_signed_mode);
        st1 = digit_step(st0.acc, st0.cnt, {4'b0000, r_data[6:4]}, r_data[7],
                         1'b1, r_signed_mode);
        use_hi = nibble && r_high;
        e0     = st0.emit;
        e1     = use_hi && st1.emit;
        acc_a  = use_hi ? st1.acc : st0.acc;
        cnt_a  = use_hi ? st1.cnt : st0.cnt;
        trunc  = r_end && (cnt_a != 4'd0) && !(e0 && e1);

        tr_res.value        = acc_a;
        tr_res.digit_count  = cnt_a;
        tr_res.status       = ST_TRUNC;
        tr_res.last_of_item = 1'b0;

        n_res = {1'b0, e0} + {1'b0, e1} + {1'b0, trunc};
        slot0 = e0 ? st0.res : (e1 ? st1.res : tr_res);
        slot1 = (e0 && e1) ? st1.res : tr_res;
        slot0.last_of_item = (n_res == 2'd1);
        slot1.last_of_item = (n_res == 2'd2);

        n_acc = trunc ? 32'd0 : acc_a;
        n_cnt = trunc ? 4'd0 : cnt_a;

        o_push.count = advance ? n_res : 2'd0;
        o_push.r0    = slot0;
        o_push.r1    = slot1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_mode  <= MODE_BYTE;
            r_signed_mode <= 1'b0;
            r_in_valid    <= 1'b0;
            r_acc         <= 32'd0;
            r_cnt         <= 4'd0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_DIGIT_MODE)) begin
                r_digit_mode <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_SIGNED_MODE)) begin
                r_signed_mode <= i_cfg_data;
            end
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_acc <= n_acc;
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_data_byte;
            r_high <= i_high_half_valid;
            r_end  <= i_buffer_end;
        end
    end

endmodule

/* src/vsd_out_queue.sv */
// result queue that takes up to two results per cycle and hands out one per cycle while the output is not stalled
module vsd_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vsd_pkg::t_push     i_push,
    input  logic               i_stall,
    output logic               o_valid,
    output vsd_pkg::t_result   o_result,
    output vsd_pkg::t_q_status o_q_status
);
    import vsd_pkg::*;

    t_result              r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_LVL_W-1:0]   r_level;
    logic [Q_LVL_W-1:0]   n_level;
    logic [Q_PTR_W-1:0]   wr_ptr_1;
    logic                 pop;

    assign o_valid  = (r_level != '0);
    assign o_result = r_q[r_rd_ptr];
    assign pop      = o_valid && !i_stall;
    assign wr_ptr_1 = r_wr_ptr + Q_PTR_W'(1);
    assign n_level  = r_level + Q_LVL_W'(i_push.count) - Q_LVL_W'(pop);

    assign o_q_status.space_ok = (r_level <= Q_LVL_W'(Q_DEPTH - 2));
    assign o_q_status.level    = r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + Q_PTR_W'(i_push.count);
            r_level  <= n_level;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_q[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_q[wr_ptr_1] <= i_push.r1;
        end
    end

endmodule

/* src/varint_stream_decoder_core.sv */
// top level of the varint stream decoder
// Decodes 32-bit unsigned LEB128-style varints from a byte stream, in 7-bit byte
// digits or one or two 3-bit nibble digits per byte, with optional zigzag decoding.
// One input byte is taken per cycle while the input is not stalled: a byte sits in
// the input register while the digit logic updates the value state, and its results
// (none, one or two) go into a four-entry result queue that drives the output ports.
// Input stalls only while the queue holds more than two results. Overflow fires at
// the fifth byte digit or eleventh nibble digit; a value left open at buffer end
// comes out truncated. Config takes effect on the next decoded digit and should
// only be written while the block is idle.
`include "assert_macros.svh"

module varint_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_high_half_valid,
    input  logic        i_buffer_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_value,
    output logic [3:0]  o_digit_count,
    output logic [1:0]  o_status,
    output logic        o_last_of_item
);
    import vsd_pkg::*;

    t_push     push;
    t_result   result;
    t_q_status q_status;

    vsd_decode u_decode (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .i_high_half_valid (i_high_half_valid),
        .i_buffer_end      (i_buffer_end),
        .i_q_status        (q_status),
        .o_push            (push)
    );

    vsd_out_queue u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_result   (result),
        .o_q_status (q_status)
    );

    assign o_value        = result.value;
    assign o_digit_count  = result.digit_count;
    assign o_status       = result.status;
    assign o_last_of_item = result.last_of_item;

    `VSD_ASSERT(a_q_level_max, q_status.level <= Q_LVL_W'(Q_DEPTH), "result queue overrun")
    `VSD_ASSERT_IMPL(a_stall_only_full, o_stall, !q_status.space_ok, "stall with queue space")
    `VSD_ASSERT_IMPL(a_push_fits, push.count != 2'd0, q_status.space_ok, "push without space")
    `VSD_ASSERT_IMPL(a_count_nonzero, o_valid, o_digit_count != 4'd0, "result with no digits")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// testbench for the varint stream decoder: directed and random byte streams with a predicting scoreboard
module testbench;
    import vsd_pkg::*;

    localparam logic [5:0] PHASE_NIBBLE = 6'b011010;
    localparam logic [5:0] PHASE_SIGNED = 6'b001100;
    localparam int         PHASE_ITEMS  = 325;
    localparam int         SETTLE       = 6;

    class decode_scoreboard;
        logic        digit_mode;
        logic        signed_mode;
        logic [31:0] acc;
        logic [3:0]  count;
        t_result     pending_values[$];
        t_result     fresh[$];
        int          errors;

        function new();
            digit_mode  = MODE_BYTE;
            signed_mode = 1'b0;
            acc         = '0;
            count       = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic idx, logic val);
            if (idx == CFG_DIGIT_MODE) begin
                digit_mode = val;
            end else begin
                signed_mode = val;
            end
        endfunction

        function void emit(logic [31:0] v, logic [1:0] st);
            t_result r;
            r.value        = v;
            r.digit_count  = count;
            r.status       = st;
            r.last_of_item = 1'b0;
            fresh.push_back(r);
            acc   = '0;
            count = '0;
        endfunction

        function void take_digit(logic [6:0] payload, logic more, int bits, int limit);
            int unsigned shift;
            shift = count * bits;
            if (shift < 32) begin
                acc = acc | (32'(payload) << shift);
            end
            if (count != CNT_MAX) begin
                count = count + 4'd1;
            end
            if (!more) begin
                emit(signed_mode ? ((acc >> 1) ^ {32{acc[0]}}) : acc, ST_OK);
            end else if (count >= limit) begin
                emit(acc, ST_OVERFLOW);
            end
        endfunction

        // predicts the results of one transferred byte
        function void decode_byte(logic [7:0] b, logic hh, logic fin);
            fresh.delete();
            if (digit_mode == MODE_BYTE) begin
                take_digit(b[6:0], b[7], int'(BYTE_BITS), int'(BYTE_LIMIT));
            end else begin
                take_digit({4'b0, b[2:0]}, b[3], int'(NIB_BITS), int'(NIB_LIMIT));
                if (hh) begin
                    take_digit({4'b0, b[6:4]}, b[7], int'(NIB_BITS), int'(NIB_LIMIT));
                end
            end
            if (fin && count != 4'd0 && fresh.size() < 2) begin
                emit(acc, ST_TRUNC);
            end
            if (fresh.size() > 0) begin
                fresh[fresh.size() - 1].last_of_item = 1'b1;
            end
            foreach (fresh[k]) begin
                pending_values.push_back(fresh[k]);
            end
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_values.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual value %0h count %0d status %0d",
                         $time, got.value, got.digit_count, got.status);
                errors++;
                return;
            end
            want = pending_values.pop_front();
            check_field("value", want.value, got.value);
            check_field("digit_count", 32'(want.digit_count), 32'(got.digit_count));
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("last_of_item", 32'(want.last_of_item), 32'(got.last_of_item));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic        i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_high_half_valid;
    logic        i_buffer_end;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_value;
    logic [3:0]  o_digit_count;
    logic [1:0]  o_status;
    logic        o_last_of_item;

    decode_scoreboard sb;
    logic             no_idle;
    logic             hold_req;

    varint_stream_decoder_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .i_high_half_valid (i_high_half_valid),
        .i_buffer_end      (i_buffer_end),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_value           (o_value),
        .o_digit_count     (o_digit_count),
        .o_status          (o_status),
        .o_last_of_item    (o_last_of_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(logic [7:0] b, logic hh, logic fin);
        while (!no_idle && $urandom_range(0, 99) < 34) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_data_byte       <= b;
        i_high_half_valid <= hh;
        i_buffer_end      <= fin;
        do @(posedge i_clk); while (o_stall);
        sb.decode_byte(b, hh, fin);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_values.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // result side
    initial begin
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (60) @(negedge i_clk);
            end
            i_stall <= !no_idle && ($urandom_range(0, 99) < 34);
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                sb.check_result('{o_value, o_digit_count, o_status, o_last_of_item});
            end
        end
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic       nib;
        logic [7:0] b;
        logic       hh;
        logic       fin;
        int         cont_pct;

        sb                = new();
        no_idle           = 1'b0;
        hold_req          = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_DIGIT_MODE;
        i_cfg_data        = 1'b0;
        i_valid           = 1'b0;
        i_data_byte       = '0;
        i_high_half_valid = 1'b0;
        i_buffer_end      = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // byte digits, unsigned
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b1, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        repeat (4) send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b0);
        repeat (5) send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h85, 1'b1, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);

        // zigzag
        write_reg(CFG_SIGNED_MODE, 1'b1);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h02, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);

        // nibble digits
        write_reg(CFG_DIGIT_MODE, MODE_NIBBLE);
        send_byte(8'h42, 1'b1, 1'b0);
        write_reg(CFG_SIGNED_MODE, 1'b0);
        send_byte(8'h8F, 1'b0, 1'b0);
        send_byte(8'h81, 1'b1, 1'b1);
        repeat (5) send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'h0F, 1'b0, 1'b0);
        send_byte(8'h0F, 1'b0, 1'b0);

        // open value continues across a mode change
        write_reg(CFG_DIGIT_MODE, MODE_BYTE);
        send_byte(8'h01, 1'b0, 1'b0);

        for (int p = 0; p < 6; p++) begin
            nib = PHASE_NIBBLE[p];
            write_reg(CFG_DIGIT_MODE, nib);
            write_reg(CFG_SIGNED_MODE, PHASE_SIGNED[p]);
            cont_pct = 50 + 20 * (p % 3);
            no_idle  = (p == 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 2 && k == 40) begin
                    hold_req = 1'b1;
                end
                if (p == 3 && k == 160) begin
                    drain();
                end
                if ($urandom_range(0, 9) == 0) begin
                    b   = 8'($urandom);
                    hh  = 1'($urandom);
                    fin = 1'($urandom);
                end else begin
                    b = 8'($urandom);
                    if (nib == MODE_BYTE) begin
                        b[7] = $urandom_range(0, 99) < cont_pct;
                        hh   = 1'($urandom);
                    end else begin
                        b[3] = $urandom_range(0, 99) < cont_pct;
                        b[7] = $urandom_range(0, 99) < cont_pct;
                        hh   = $urandom_range(0, 4) != 0;
                    end
                    fin = $urandom_range(0, 19) == 0;
                end
                send_byte(b, hh, fin);
            end
        end

        no_idle = 1'b0;
        i_valid <= 1'b0;
        while (sb.pending_values.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_values.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+src
src/vsd_pkg.sv
src/vsd_decode.sv
src/vsd_out_queue.sv
src/varint_stream_decoder_core.sv
tb/testbench.sv
